### hdl/ilist_pkg.sv
// ----------------------------------------------------------------------------
// ilist_pkg: shared types and constants for the indexed list unit
// Holds the list geometry, opcodes, status codes, address select codes and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ilist_pkg;

  // list geometry
  localparam int LIST_DEPTH = 64;
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;  // entry index
  localparam int CW = $clog2(LIST_DEPTH + 1);                     // entry count
  localparam int PW = ((CW > 7) ? CW : 7) + 1;                    // signed position math
  localparam int VW = 32;

  // opcodes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // memory address selects
  localparam logic [1:0] ASEL_IDX    = 2'd0;
  localparam logic [1:0] ASEL_PTR    = 2'd1;
  localparam logic [1:0] ASEL_PTR_UP = 2'd2;
  localparam logic [1:0] ASEL_COUNT  = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic       accept;    // latch request and check it
    logic       rd_en;     // memory read
    logic [1:0] rd_sel;
    logic       wr_en;     // memory write
    logic [1:0] wr_sel;
    logic       wr_rdata;  // write read data instead of request value
    logic       ptr_top;   // ptr = count - 1
    logic       ptr_idx;   // ptr = resolved index
    logic       ptr_dec;
    logic       ptr_inc;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cap_res;   // capture read data as result value
    logic       out_load;  // load output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       ok;          // request passed its checks
    logic       ptr_at_idx;  // ptr == resolved index
    logic       ptr_last1;   // ptr + 1 == count
    logic       ptr_last2;   // ptr + 2 == count
    logic       out_free;    // output register can take a result
  } dp_stat_t;

endpackage

`default_nettype wire

### hdl/ilist_dpath.sv
// ----------------------------------------------------------------------------
// ilist_dpath: datapath of the indexed list unit
// Entry memory, count, shift pointer, request checks and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ilist_dpath (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ilist_pkg::dp_cmd_t       cmd,
  output      ilist_pkg::dp_stat_t      stat,
  input  wire logic [1:0]               opcode,
  input  wire logic signed [6:0]        position,
  input  wire logic [ilist_pkg::VW-1:0] entry_value,
  output      logic                     out_valid,
  input  wire logic                     out_ready,
  output      logic [ilist_pkg::VW-1:0] read_value,
  output      logic [1:0]               status,
  output      logic [6:0]               entry_count
);

  localparam int AW  = ilist_pkg::AW;
  localparam int CW  = ilist_pkg::CW;
  localparam int CW1 = ilist_pkg::CW + 1;
  localparam int PW  = ilist_pkg::PW;
  localparam int VW  = ilist_pkg::VW;

  logic [VW-1:0] mem [ilist_pkg::LIST_DEPTH];
  logic [VW-1:0] rdata;
  logic [CW-1:0] count;
  logic [AW-1:0] ptr;
  logic [AW-1:0] idx;
  logic [1:0]    op;
  logic [1:0]    st;
  logic [VW-1:0] val;
  logic [VW-1:0] res;

  logic signed [PW-1:0] pos_s, cnt_s, res_p;
  logic                 in_rng, is_full, is_empty;
  logic [1:0]           st_next;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [CW1-1:0]       ptr_w, cnt_w;

  // resolve position against the current count
  always_comb begin
    pos_s    = PW'(position);
    cnt_s    = signed'(PW'(count));
    res_p    = pos_s[PW-1] ? (pos_s + cnt_s) : pos_s;
    in_rng   = !res_p[PW-1] && (res_p < cnt_s);
    is_full  = (count == CW'(ilist_pkg::LIST_DEPTH));
    is_empty = (count == '0);
    st_next  = ilist_pkg::ST_OK;
    case (opcode)
      ilist_pkg::OP_APPEND: begin
        if (is_full) st_next = ilist_pkg::ST_FULL;
      end
      ilist_pkg::OP_INSERT: begin
        if (!in_rng)      st_next = ilist_pkg::ST_RANGE;
        else if (is_full) st_next = ilist_pkg::ST_FULL;
      end
      default: begin
        if (is_empty)     st_next = ilist_pkg::ST_EMPTY;
        else if (!in_rng) st_next = ilist_pkg::ST_RANGE;
      end
    endcase
  end

  // request registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op  <= opcode;
      idx <= res_p[AW-1:0];
      val <= entry_value;
      st  <= st_next;
    end
  end

  // address selection
  always_comb begin
    unique case (cmd.rd_sel)
      ilist_pkg::ASEL_IDX:    rd_addr = idx;
      ilist_pkg::ASEL_PTR:    rd_addr = ptr;
      ilist_pkg::ASEL_PTR_UP: rd_addr = ptr + AW'(1);
      ilist_pkg::ASEL_COUNT:  rd_addr = count[AW-1:0];
      default:                rd_addr = idx;
    endcase
    unique case (cmd.wr_sel)
      ilist_pkg::ASEL_IDX:    wr_addr = idx;
      ilist_pkg::ASEL_PTR:    wr_addr = ptr;
      ilist_pkg::ASEL_PTR_UP: wr_addr = ptr + AW'(1);
      ilist_pkg::ASEL_COUNT:  wr_addr = count[AW-1:0];
      default:                wr_addr = idx;
    endcase
  end

  // entry memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= cmd.wr_rdata ? rdata : val;
    if (cmd.rd_en) rdata <= mem[rd_addr];
  end

  // count and shift pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ptr_top)      ptr <= AW'(count - CW'(1));
    else if (cmd.ptr_idx) ptr <= idx;
    else if (cmd.ptr_dec) ptr <= ptr - AW'(1);
    else if (cmd.ptr_inc) ptr <= ptr + AW'(1);
  end

  // result value: zero unless a read or remove succeeds
  always_ff @(posedge clk) begin
    if (cmd.accept)       res <= '0;
    else if (cmd.cap_res) res <= rdata;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_value  <= res;
      status      <= st;
      entry_count <= 7'(count);
    end
  end

  // status back to the controller
  assign ptr_w = CW1'(ptr);
  assign cnt_w = CW1'(count);
  always_comb begin
    stat.op         = op;
    stat.ok         = (st == ilist_pkg::ST_OK);
    stat.ptr_at_idx = (ptr == idx);
    stat.ptr_last1  = ((ptr_w + CW1'(1)) == cnt_w);
    stat.ptr_last2  = ((ptr_w + CW1'(2)) == cnt_w);
    stat.out_free   = !out_valid || out_ready;
  end

`ifndef SYNTH
  // count stays within the list depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ilist_pkg::LIST_DEPTH))
    else $error("entry count above list depth");

  // count never moves both ways at once
  a_count_dir: assert property (@(posedge clk) disable iff (rst)
    !(cmd.cnt_inc && cmd.cnt_dec))
    else $error("count increment and decrement together");

  // growing the list only happens below full
  a_grow_room: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !is_full)
    else $error("count increment on a full list");

  // a pending result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");
`endif

endmodule

`default_nettype wire

### hdl/ilist_ctrl.sv
// ----------------------------------------------------------------------------
// ilist_ctrl: controller of the indexed list unit
// Sequences each request: check, memory shift loop, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ilist_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire ilist_pkg::dp_stat_t stat,
  output      ilist_pkg::dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECIDE  = 4'd1;
  localparam logic [3:0] S_INS_RD  = 4'd2;
  localparam logic [3:0] S_INS_WR  = 4'd3;
  localparam logic [3:0] S_INS_PUT = 4'd4;
  localparam logic [3:0] S_RD_WAIT = 4'd5;
  localparam logic [3:0] S_REM_RD  = 4'd6;
  localparam logic [3:0] S_REM_WR  = 4'd7;
  localparam logic [3:0] S_REM_END = 4'd8;
  localparam logic [3:0] S_FINISH  = 4'd9;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_ready = (state == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!stat.ok) begin
          state_next = S_FINISH;
        end else begin
          unique case (stat.op) inside
            ilist_pkg::OP_APPEND: begin
              cmd.wr_en   = 1'b1;
              cmd.wr_sel  = ilist_pkg::ASEL_COUNT;
              cmd.cnt_inc = 1'b1;
              state_next  = S_FINISH;
            end
            ilist_pkg::OP_INSERT: begin
              cmd.ptr_top = 1'b1;
              state_next  = S_INS_RD;
            end
            ilist_pkg::OP_REMOVE, ilist_pkg::OP_READ: begin
              cmd.rd_en   = 1'b1;
              cmd.rd_sel  = ilist_pkg::ASEL_IDX;
              cmd.ptr_idx = 1'b1;
              state_next  = S_RD_WAIT;
            end
            default: state_next = S_FINISH;
          endcase
        end
      end
      // insert: move entries up from the top down to the index
      S_INS_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ilist_pkg::ASEL_PTR;
        state_next = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = ilist_pkg::ASEL_PTR_UP;
        cmd.wr_rdata = 1'b1;
        if (stat.ptr_at_idx) begin
          state_next = S_INS_PUT;
        end else begin
          cmd.ptr_dec = 1'b1;
          state_next  = S_INS_RD;
        end
      end
      S_INS_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = ilist_pkg::ASEL_IDX;
        cmd.cnt_inc = 1'b1;
        state_next  = S_FINISH;
      end
      // read or remove: take the entry, then close the gap for remove
      S_RD_WAIT: begin
        cmd.cap_res = 1'b1;
        if (stat.op != ilist_pkg::OP_REMOVE) state_next = S_FINISH;
        else if (stat.ptr_last1)             state_next = S_REM_END;
        else                                 state_next = S_REM_RD;
      end
      S_REM_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ilist_pkg::ASEL_PTR_UP;
        state_next = S_REM_WR;
      end
      S_REM_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = ilist_pkg::ASEL_PTR;
        cmd.wr_rdata = 1'b1;
        if (stat.ptr_last2) begin
          state_next = S_REM_END;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_REM_RD;
        end
      end
      S_REM_END: begin
        cmd.cnt_dec = 1'b1;
        state_next  = S_FINISH;
      end
      // hand the result to the output register
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### hdl/indexed_list_insert_remove_unit.sv
// Append and failed requests pass from the check straight to the hand-off; read adds a memory read.
// Insert and remove also move every entry that lies between the index and the top of the list.
// One request at a time; the next can be taken in the cycle the previous result appears.
// Moving entries (a registered read, then a write, per entry) sets the insert/remove time.
// A result not yet taken by the receiver holds the unit in its hand-off state.
// Reset clears the entry count and the output valid; memory contents stay undefined.
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_unit: ordered list store of fixed depth
// Append, insert before, remove at and read a position, with status and count.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_remove_unit (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output      logic                     in_ready,
  input  wire logic [1:0]               opcode,
  input  wire logic signed [6:0]        position,
  input  wire logic [ilist_pkg::VW-1:0] entry_value,
  output      logic                     out_valid,
  input  wire logic                     out_ready,
  output      logic [ilist_pkg::VW-1:0] read_value,
  output      logic [1:0]               status,
  output      logic [6:0]               entry_count
);

  ilist_pkg::dp_cmd_t  cmd;
  ilist_pkg::dp_stat_t stat;

  ilist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ilist_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .opcode      (opcode),
    .position    (position),
    .entry_value (entry_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule

`default_nettype wire

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for indexed_list_insert_remove_unit
// Drives append, insert, remove and read requests through the valid/ready
// input channel and keeps a shadow copy of the list. Every reply is checked
// field by field against the shadow list's answer. The stimulus covers
// directed corners, a full fill and drain, random phases with sender and
// receiver idling, and a long receiver hold that backs up the input.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [ilist_pkg::VW-1:0] value;
    logic [1:0]               status;
    logic [6:0]               count;
  } list_reply_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               opcode = ilist_pkg::OP_APPEND;
  logic signed [6:0]        position = '0;
  logic [ilist_pkg::VW-1:0] entry_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [ilist_pkg::VW-1:0] read_value;
  logic [1:0]               status;
  logic [6:0]               entry_count;

  // shadow copy of the list contents, head of the list at index 0
  logic [ilist_pkg::VW-1:0] shadow_list[$];
  // replies owed by the block, in request order
  list_reply_t              pending_replies[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_cycles    = 0;
  int error_count    = 0;

  indexed_list_insert_remove_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .position    (position),
    .entry_value (entry_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count)
  );

  always #10 clk = ~clk;

  // Apply one request to the shadow list and return the reply it should give
  function automatic list_reply_t apply_list_op(input logic [1:0] op,
                                                input logic signed [6:0] pos,
                                                input logic [ilist_pkg::VW-1:0] val);
    list_reply_t r;
    int          n;
    int          p;
    bit          hit;
    n = shadow_list.size();
    p = pos;
    if (p < 0) p += n;  // negative positions count back from the end
    hit = (p >= 0) && (p < n);
    r.value  = '0;
    r.status = ilist_pkg::ST_OK;
    case (op)
      ilist_pkg::OP_APPEND: begin
        if (n >= ilist_pkg::LIST_DEPTH) r.status = ilist_pkg::ST_FULL;
        else shadow_list.push_back(val);
      end
      ilist_pkg::OP_INSERT: begin
        // position is checked before fullness
        if (!hit) r.status = ilist_pkg::ST_RANGE;
        else if (n >= ilist_pkg::LIST_DEPTH) r.status = ilist_pkg::ST_FULL;
        else shadow_list.insert(p, val);
      end
      default: begin
        if (n == 0) begin
          r.status = ilist_pkg::ST_EMPTY;
        end else if (!hit) begin
          r.status = ilist_pkg::ST_RANGE;
        end else begin
          r.value = shadow_list[p];
          if (op == ilist_pkg::OP_REMOVE) shadow_list.delete(p);
        end
      end
    endcase
    r.count = 7'(shadow_list.size());
    return r;
  endfunction

  // Receiver: random stalls, or a forced hold while hold_cycles runs down
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Reply checker
  always @(posedge clk) begin
    list_reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected reply: value %h status %0d count %0d",
                   read_value, status, entry_count);
      end else begin
        want = pending_replies.pop_front();
        if (read_value !== want.value || status !== want.status ||
            entry_count !== want.count) begin
          error_count++;
          if (error_count <= 10)
            $display({"reply mismatch: value exp %h got %h, ",
                      "status exp %0d got %0d, count exp %0d got %0d"},
                     want.value, read_value, want.status, status,
                     want.count, entry_count);
        end
      end
    end
  end

  // Send one request; returns at the edge where it is taken
  task automatic send_request(input logic [1:0] op, input logic signed [6:0] pos,
                              input logic [ilist_pkg::VW-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    position    <= pos;
    entry_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_replies.push_back(apply_list_op(op, pos, val));
  endtask

  // Drop valid and wait for every owed reply
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  // Random request steered toward a target fill level
  task automatic send_random_request(input int target);
    int                n;
    int                r;
    int                idx;
    logic [1:0]        op;
    logic signed [6:0] pos;
    n = shadow_list.size();
    r = $urandom_range(99);
    if (r < 20) op = ilist_pkg::OP_READ;
    else if ((n < target) ? (r < 72) : (r < 40))
      op = $urandom_range(1) ? ilist_pkg::OP_APPEND : ilist_pkg::OP_INSERT;
    else op = ilist_pkg::OP_REMOVE;
    // mostly positions that name an entry, in either form; some raw noise
    if (n == 0 || $urandom_range(99) < 15) begin
      pos = 7'($urandom_range(127));
    end else begin
      idx = $urandom_range(n - 1);
      pos = $urandom_range(1) ? 7'(idx - n) : 7'(idx);
    end
    send_request(op, pos, $urandom);
  endtask

  task automatic test_directed();
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    // empty list corners
    send_request(ilist_pkg::OP_READ,   7'sd0,   32'h1111_1111);
    send_request(ilist_pkg::OP_REMOVE, -7'sd1,  32'h0);
    send_request(ilist_pkg::OP_INSERT, 7'sd0,   32'h2222_2222);
    // appends ignore position; value extremes
    send_request(ilist_pkg::OP_APPEND, -7'sd64, 32'h0000_0000);
    send_request(ilist_pkg::OP_APPEND, 7'sd63,  32'hFFFF_FFFF);
    send_request(ilist_pkg::OP_APPEND, 7'sd0,   32'hA5A5_A5A5);
    // reads at both ends and just past them
    send_request(ilist_pkg::OP_READ,   -7'sd1,  32'h0);
    send_request(ilist_pkg::OP_READ,   -7'sd3,  32'h0);
    send_request(ilist_pkg::OP_READ,   7'sd3,   32'h0);
    send_request(ilist_pkg::OP_READ,   -7'sd4,  32'h0);
    send_request(ilist_pkg::OP_READ,   7'sd63,  32'h0);
    send_request(ilist_pkg::OP_READ,   -7'sd64, 32'h0);
    // inserts at head, before last, at last, one past the end
    send_request(ilist_pkg::OP_INSERT, 7'sd0,   32'h1234_5678);
    send_request(ilist_pkg::OP_INSERT, -7'sd1,  32'h5A5A_5A5A);
    send_request(ilist_pkg::OP_INSERT, 7'sd4,   32'h8000_0001);
    send_request(ilist_pkg::OP_INSERT, 7'sd6,   32'h7FFF_FFFE);
    send_request(ilist_pkg::OP_INSERT, -7'sd7,  32'hDEAD_BEEF);
    // removes at head, tail, middle, out of range
    send_request(ilist_pkg::OP_REMOVE, 7'sd0,   32'h0);
    send_request(ilist_pkg::OP_REMOVE, -7'sd1,  32'h0);
    send_request(ilist_pkg::OP_REMOVE, 7'sd2,   32'h0);
    send_request(ilist_pkg::OP_REMOVE, 7'sd10,  32'h0);
    send_request(ilist_pkg::OP_READ,   7'sd1,   32'h0);
    wait_drained();
  endtask

  task automatic test_fill_drain();
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    while (shadow_list.size() < ilist_pkg::LIST_DEPTH)
      send_request(ilist_pkg::OP_APPEND, 7'($urandom_range(127)), $urandom);
    // full list: appends and inserts refused, every position is valid
    send_request(ilist_pkg::OP_APPEND, 7'sd0,   $urandom);
    send_request(ilist_pkg::OP_INSERT, 7'sd0,   $urandom);
    send_request(ilist_pkg::OP_INSERT, -7'sd64, $urandom);
    send_request(ilist_pkg::OP_READ,   7'sd63,  32'h0);
    send_request(ilist_pkg::OP_READ,   -7'sd64, 32'h0);
    send_request(ilist_pkg::OP_REMOVE, -7'sd64, 32'h0);
    send_request(ilist_pkg::OP_INSERT, 7'sd62,  $urandom);
    send_request(ilist_pkg::OP_REMOVE, 7'sd63,  32'h0);
    while (shadow_list.size() > 0)
      send_request(ilist_pkg::OP_REMOVE, 7'($urandom_range(shadow_list.size() - 1)),
                   32'h0);
    send_request(ilist_pkg::OP_REMOVE, 7'sd0, 32'h0);
    wait_drained();
  endtask

  task automatic run_random_phase(input int items, input int send_pct, input int recv_pct);
    int target;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    target         = 0;
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(3))
          0:       target = ilist_pkg::LIST_DEPTH;
          1:       target = 0;
          default: target = $urandom_range(ilist_pkg::LIST_DEPTH);
        endcase
      end
      send_random_request(target);
    end
    wait_drained();
  endtask

  task automatic test_random();
    run_random_phase(130, 0, 0);
    run_random_phase(130, 58, 0);
    run_random_phase(130, 0, 58);
    run_random_phase(130, 24, 24);
  endtask

  // Long receiver hold while requests keep coming
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles   <= 400;
    for (int i = 0; i < 12; i++) send_random_request(ilist_pkg::LIST_DEPTH / 2);
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_drain();
    test_random();
    test_backpressure();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(20 * 1000000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### indexed_list_insert_remove_unit.f
hdl/ilist_pkg.sv
hdl/ilist_dpath.sv
hdl/ilist_ctrl.sv
hdl/indexed_list_insert_remove_unit.sv
test/testbench.sv
